// ===== rtl/sacl_pkg.sv =====
// Shared constants for the set-associative cache tag and LRU engine.
// Fixed field widths of the request and response words and the access codes.
// No dependencies.
package sacl_pkg;

    localparam int ADDR_W      = 32;
    localparam int TAG_FIELD_W = 20;
    localparam int WAY_FIELD_W = 2;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

endpackage

// ===== rtl/set_assoc_cache_lru_tags.sv =====
// Tag and LRU engine of a set-associative write-back, write-allocate cache.
// Depends on sacl_pkg for field widths and access codes.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one word per access:
//   addr and action (read or write). Response channel (rsp_valid /
//   rsp_stall) returns one word per access: hit, way_used, evicted,
//   writeback and evicted_tag. A word moves at a clock edge where valid is
//   high and stall is low.
//   An accepted request is registered in the lookup stage, and its result
//   in the response register. The block takes one access per cycle while
//   the response register is not held by rsp_stall: a set's row is read from
//   the tag and state memories at accept, updated in the lookup stage and
//   written back as the access leaves it, and the last row written is
//   forwarded to a following access of the same set.
//   After reset the state memory is swept one set per cycle to clear valid
//   and dirty bits and load the age counters; the sweep covers 2**floor(log2
//   NUM_SETS) sets (64 at the default), and req_stall is high during it.
//   Tag memory is not cleared; a tag is only looked at when its line is valid.
//   When rsp_stall holds the response register, one more access finishes
//   into the lookup stage, then req_stall rises until the response drains.
module set_assoc_cache_lru_tags #(
    parameter int NUM_SETS    = 64,
    parameter int NUM_WAYS    = 4,
    parameter int OFFSET_BITS = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]        addr,
    input  logic                               action,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               hit,
    output logic [sacl_pkg::WAY_FIELD_W-1:0]   way_used,
    output logic                               evicted,
    output logic                               writeback,
    output logic [sacl_pkg::TAG_FIELD_W-1:0]   evicted_tag
);
    import sacl_pkg::*;

    localparam int IDX_BITS  = $clog2(NUM_SETS + 1) - 1;
    localparam int SET_AW    = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int SET_DEPTH = 1 << IDX_BITS;
    localparam int TAG_W     = ADDR_W - OFFSET_BITS - IDX_BITS;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W     = WAY_W;

    typedef struct packed {
        logic [NUM_WAYS-1:0]            valid;
        logic [NUM_WAYS-1:0]            dirty;
        logic [NUM_WAYS-1:0][AGE_W-1:0] age;
    } meta_t;

    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

    // set memories
    meta_t    meta_mem [SET_DEPTH];
    tag_row_t tag_mem  [SET_DEPTH];
    meta_t    rd_meta_reg;
    tag_row_t rd_tags_reg;

    // clearing sweep
    logic              clr_active_reg;
    logic [SET_AW-1:0] clr_addr_reg;

    // lookup stage
    logic              s1_valid_reg;
    logic [SET_AW-1:0] s1_set_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    logic              s1_write_reg;

    // forwarding of the last row written
    logic              fwd_valid_reg;
    logic [SET_AW-1:0] fwd_set_reg;
    meta_t             fwd_meta_reg;
    tag_row_t          fwd_tags_reg;

    // response register
    logic                   rsp_valid_reg;
    logic                   hit_reg;
    logic [WAY_FIELD_W-1:0] way_used_reg;
    logic                   evicted_reg;
    logic                   writeback_reg;
    logic [TAG_FIELD_W-1:0] evicted_tag_reg;

    logic              req_acc;
    logic              s1_adv;
    logic [SET_AW-1:0] req_set;
    logic [TAG_W-1:0]  req_tag;

    meta_t             rst_meta;
    meta_t             cur_meta;
    tag_row_t          cur_tags;
    meta_t             new_meta;
    tag_row_t          new_tags;
    logic              hit_any;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  vict_way;
    logic [WAY_W-1:0]  use_way;
    logic [AGE_W-1:0]  use_age;
    logic              ev;
    logic              wb;
    logic [TAG_FIELD_W-1:0] etag;

    logic              meta_we;
    logic [SET_AW-1:0] meta_wa;
    meta_t             meta_wd;

    assign req_set = (IDX_BITS == 0) ? '0 : SET_AW'(addr >> OFFSET_BITS);
    assign req_tag = TAG_W'(addr >> (OFFSET_BITS + IDX_BITS));

    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = clr_active_reg || (s1_valid_reg && !s1_adv);
    assign req_acc   = req_valid && !req_stall;

    always_comb
    begin
        rst_meta = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            rst_meta.age[w] = AGE_W'(w);
        end
    end

    // lookup, victim choice and age update
    always_comb
    begin
        if (fwd_valid_reg && (fwd_set_reg == s1_set_reg))
        begin
            cur_meta = fwd_meta_reg;
            cur_tags = fwd_tags_reg;
        end
        else
        begin
            cur_meta = rd_meta_reg;
            cur_tags = rd_tags_reg;
        end

        hit_any  = 1'b0;
        hit_way  = '0;
        vict_way = '0;
        // ages stay a permutation of the way numbers, so the oldest way is unique
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (cur_meta.valid[w] && (cur_tags[w] == s1_tag_reg))
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (cur_meta.age[w] == AGE_W'(NUM_WAYS - 1))
            begin
                vict_way = WAY_W'(w);
            end
        end

        use_way  = hit_any ? hit_way : vict_way;
        use_age  = cur_meta.age[use_way];
        new_meta = cur_meta;
        new_tags = cur_tags;

        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == use_way)
            begin
                new_meta.age[w] = '0;
            end
            else if (cur_meta.age[w] < use_age)
            begin
                new_meta.age[w] = cur_meta.age[w] + AGE_W'(1);
            end
        end

        if (hit_any)
        begin
            if (s1_write_reg == ACT_WRITE)
            begin
                new_meta.dirty[use_way] = 1'b1;
            end
        end
        else
        begin
            new_tags[use_way]       = s1_tag_reg;
            new_meta.valid[use_way] = 1'b1;
            new_meta.dirty[use_way] = (s1_write_reg == ACT_WRITE);
        end

        ev   = !hit_any && cur_meta.valid[vict_way];
        wb   = ev && cur_meta.dirty[vict_way];
        etag = ev ? TAG_FIELD_W'(cur_tags[vict_way]) : '0;
    end

    assign meta_we = clr_active_reg || s1_adv;
    assign meta_wa = clr_active_reg ? clr_addr_reg : s1_set_reg;
    assign meta_wd = clr_active_reg ? rst_meta : new_meta;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (req_acc)
        begin
            rd_meta_reg <= meta_mem[req_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && !hit_any)
        begin
            tag_mem[s1_set_reg] <= new_tags;
        end
        if (req_acc)
        begin
            rd_tags_reg <= tag_mem[req_set];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == SET_AW'(SET_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + SET_AW'(1);
            end

            if (req_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                fwd_valid_reg <= 1'b1;
            end

            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_set_reg   <= req_set;
            s1_tag_reg   <= req_tag;
            s1_write_reg <= action;
        end
        if (s1_adv)
        begin
            fwd_set_reg     <= s1_set_reg;
            fwd_meta_reg    <= new_meta;
            fwd_tags_reg    <= new_tags;
            hit_reg         <= hit_any;
            way_used_reg    <= WAY_FIELD_W'(use_way);
            evicted_reg     <= ev;
            writeback_reg   <= wb;
            evicted_tag_reg <= etag;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign hit         = hit_reg;
    assign way_used    = way_used_reg;
    assign evicted     = evicted_reg;
    assign writeback   = writeback_reg;
    assign evicted_tag = evicted_tag_reg;

endmodule

// ===== tb/cache_lookup_checker.sv =====
// Checker for the cache tag and LRU engine: watches both channels, predicts each lookup
// from its own copy of tags, valid, dirty and age bits, and compares every response word.
// Depends on sacl_pkg for field widths and access codes.
module cache_lookup_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]      addr,
    input  logic                             action,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic                             hit,
    input  logic [sacl_pkg::WAY_FIELD_W-1:0] way_used,
    input  logic                             evicted,
    input  logic                             writeback,
    input  logic [sacl_pkg::TAG_FIELD_W-1:0] evicted_tag,
    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SETS   = 64;
    localparam int N_WAYS   = 4;
    localparam int OFF_BITS = 6;
    localparam int SET_BITS = 6;
    localparam int TAG_LSB  = OFF_BITS + SET_BITS;

    typedef struct packed {
        logic                             hit;
        logic [sacl_pkg::WAY_FIELD_W-1:0] way;
        logic                             evicted;
        logic                             writeback;
        logic [sacl_pkg::TAG_FIELD_W-1:0] tag;
    } lookup_t;

    lookup_t expected_lookups[$];

    logic [sacl_pkg::TAG_FIELD_W-1:0] line_tag   [N_SETS][N_WAYS];
    logic                             line_valid [N_SETS][N_WAYS];
    logic                             line_dirty [N_SETS][N_WAYS];
    logic [1:0]                       line_age   [N_SETS][N_WAYS];

    int responses_seen;

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("[%0t] MISMATCH response %0d %s: expected 0x%0h, got 0x%0h",
                 $realtime, responses_seen, what, want, got);
        mismatches++;
    endtask

    // Age every way younger than the used one, then make the used way most recent.
    function automatic void promote_way(int s, int w);
        logic [1:0] cur;
        cur = line_age[s][w];
        for (int i = 0; i < N_WAYS; i++)
            if (line_age[s][i] < cur)
                line_age[s][i] = line_age[s][i] + 2'd1;
        line_age[s][w] = 2'd0;
    endfunction

    function automatic lookup_t predict_lookup(logic [sacl_pkg::ADDR_W-1:0] a, logic act);
        lookup_t                          r;
        int                               s;
        int                               victim;
        logic [1:0]                       oldest;
        logic [sacl_pkg::TAG_FIELD_W-1:0] t;
        bit                               found;
        s     = int'(a[OFF_BITS +: SET_BITS]);
        t     = a[sacl_pkg::ADDR_W-1:TAG_LSB];
        r     = '0;
        found = 1'b0;
        for (int w = 0; w < N_WAYS; w++)
        begin
            if (!found && line_valid[s][w] && line_tag[s][w] == t)
            begin
                found = 1'b1;
                r.hit = 1'b1;
                r.way = w[sacl_pkg::WAY_FIELD_W-1:0];
                promote_way(s, w);
                if (act == sacl_pkg::ACT_WRITE)
                    line_dirty[s][w] = 1'b1;
            end
        end
        if (!found)
        begin
            // Victim: lowest way holding the strictly largest age, way 0 if all are zero.
            victim = 0;
            oldest = 2'd0;
            for (int w = 0; w < N_WAYS; w++)
            begin
                if (line_age[s][w] > oldest)
                begin
                    oldest = line_age[s][w];
                    victim = w;
                end
            end
            if (line_valid[s][victim])
            begin
                r.evicted   = 1'b1;
                r.writeback = line_dirty[s][victim];
                r.tag       = line_tag[s][victim];
            end
            line_tag[s][victim]   = t;
            line_valid[s][victim] = 1'b1;
            line_dirty[s][victim] = (act == sacl_pkg::ACT_WRITE);
            promote_way(s, victim);
            r.way = victim[sacl_pkg::WAY_FIELD_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < N_SETS; s++)
            begin
                for (int w = 0; w < N_WAYS; w++)
                begin
                    line_tag[s][w]   = '0;
                    line_valid[s][w] = 1'b0;
                    line_dirty[s][w] = 1'b0;
                    line_age[s][w]   = w[1:0];
                end
            end
            expected_lookups.delete();
            outstanding    = 0;
            mismatches     = 0;
            responses_seen = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_lookups.size() == 0)
                    report_mismatch("arrived with no access pending", 0, 1);
                else
                begin
                    want = expected_lookups.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", 32'(want.hit), 32'(hit));
                    if (way_used !== want.way)
                        report_mismatch("way_used", 32'(want.way), 32'(way_used));
                    if (evicted !== want.evicted)
                        report_mismatch("evicted", 32'(want.evicted), 32'(evicted));
                    if (writeback !== want.writeback)
                        report_mismatch("writeback", 32'(want.writeback), 32'(writeback));
                    if (evicted_tag !== want.tag)
                        report_mismatch("evicted_tag", 32'(want.tag), 32'(evicted_tag));
                end
                responses_seen++;
            end
            if (req_valid && !req_stall)
                expected_lookups.push_back(predict_lookup(addr, action));
            outstanding = expected_lookups.size();
        end
    end

endmodule

// ===== tb/set_assoc_cache_lru_tags_tb.sv =====
// Top of the cache tag and LRU engine testbench: clock, reset, access stimulus and verdict.
// Depends on sacl_pkg, set_assoc_cache_lru_tags and cache_lookup_checker.
module set_assoc_cache_lru_tags_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ACCESSES = 1350;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_START      = 300;
    localparam int HOLD_LEN        = 80;
    localparam int DRAIN_CYCLES    = 8;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             req_valid;
    logic                             req_stall;
    logic [sacl_pkg::ADDR_W-1:0]      addr;
    logic                             action;
    logic                             rsp_valid;
    logic                             rsp_stall;
    logic                             hit;
    logic [sacl_pkg::WAY_FIELD_W-1:0] way_used;
    logic                             evicted;
    logic                             writeback;
    logic [sacl_pkg::TAG_FIELD_W-1:0] evicted_tag;

    logic stall_pattern;
    logic long_hold;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;

    logic [sacl_pkg::TAG_FIELD_W-1:0] tag_pool [6];
    logic [5:0]                       hot_sets [4];

    assign rsp_stall = stall_pattern | long_hold;

    always #6 clk = ~clk;

    set_assoc_cache_lru_tags #(
        .NUM_SETS    (64),
        .NUM_WAYS    (4),
        .OFFSET_BITS (6)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .addr        (addr),
        .action      (action),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit         (hit),
        .way_used    (way_used),
        .evicted     (evicted),
        .writeback   (writeback),
        .evicted_tag (evicted_tag)
    );

    cache_lookup_checker lookup_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .addr        (addr),
        .action      (action),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit         (hit),
        .way_used    (way_used),
        .evicted     (evicted),
        .writeback   (writeback),
        .evicted_tag (evicted_tag),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic logic [sacl_pkg::ADDR_W-1:0] make_addr(
        logic [sacl_pkg::TAG_FIELD_W-1:0] t, logic [5:0] s, logic [5:0] off);
        return {t, s, off};
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_access(input logic [sacl_pkg::ADDR_W-1:0] a, input logic act);
        @(negedge clk);
        req_valid <= 1'b1;
        addr      <= a;
        action    <= act;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver stalls in segments: free running, coin flip, periodic, or mostly stalled.
    initial
    begin
        int seg_len;
        int mode;
        int period;
        stall_pattern = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 60);
            period  = $urandom_range(2, 5);
            for (int i = 0; i < seg_len; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       stall_pattern <= 1'b0;
                    1:       stall_pattern <= 1'($urandom_range(0, 1));
                    2:       stall_pattern <= ((i % period) == 0);
                    default: stall_pattern <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // One long hold-off while the sender keeps offering, so the block backs up.
    initial
    begin
        long_hold = 1'b0;
        wait (rst_n === 1'b1);
        repeat (HOLD_START) @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        int                          sent;
        int                          burst;
        int                          gap;
        int                          pick;
        logic [sacl_pkg::ADDR_W-1:0] a;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        addr      = '0;
        action    = sacl_pkg::ACT_READ;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = 20'($urandom_range(0, 20'hFFFFF));
        hot_sets[0] = 6'd0;
        hot_sets[1] = 6'd63;
        hot_sets[2] = 6'($urandom_range(1, 62));
        hot_sets[3] = 6'($urandom_range(1, 62));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Address extremes, hit on the same line at another offset, write hit marking dirty.
        send_access('0, sacl_pkg::ACT_READ);
        send_access('1, sacl_pkg::ACT_WRITE);
        send_access(make_addr(20'hFFFFF, 6'd63, 6'd0), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h00000, 6'd0, 6'd63), sacl_pkg::ACT_WRITE);
        // Fill one set, then miss so that clean and dirty victims leave.
        send_access(make_addr(20'hA5A5A, 6'd5, 6'd1), sacl_pkg::ACT_WRITE);
        send_access(make_addr(20'h5A5A5, 6'd5, 6'd2), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h12345, 6'd5, 6'd3), sacl_pkg::ACT_WRITE);
        send_access(make_addr(20'hFEDCB, 6'd5, 6'd4), sacl_pkg::ACT_READ);
        send_access(make_addr(20'hA5A5A, 6'd5, 6'd5), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h00001, 6'd5, 6'd6), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h80000, 6'd5, 6'd7), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h00001, 6'd5, 6'd8), sacl_pkg::ACT_WRITE);
        send_access(make_addr(20'hA5A5A, 6'd5, 6'd9), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h5A5A5, 6'd5, 6'd10), sacl_pkg::ACT_READ);
        // Push the all-ones dirty line out of the top set.
        send_access(make_addr(20'h00001, 6'd63, 6'd0), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h00002, 6'd63, 6'd0), sacl_pkg::ACT_READ);
        send_access(make_addr(20'h00003, 6'd63, 6'd0), sacl_pkg::ACT_WRITE);
        send_access(make_addr(20'h00004, 6'd63, 6'd0), sacl_pkg::ACT_READ);
        send_access(make_addr(20'hFFFFF, 6'd63, 6'd5), sacl_pkg::ACT_WRITE);

        // Mostly a small tag pool over a few sets so hits, evictions and write-backs mix.
        sent = 0;
        while (sent < RANDOM_ACCESSES)
        begin
            if ($urandom_range(0, 7) == 0)
                tag_pool[$urandom_range(0, 5)] = 20'($urandom_range(0, 20'hFFFFF));
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ACCESSES; i++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    a = $urandom;
                else if (pick < 4)
                    a = make_addr(tag_pool[$urandom_range(0, 5)], 6'($urandom_range(0, 63)),
                                  6'($urandom_range(0, 63)));
                else
                    a = make_addr(tag_pool[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)],
                                  6'($urandom_range(0, 63)));
                send_access(a, 1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                addr      <= $urandom;
                action    <= 1'($urandom_range(0, 1));
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
